@@ design/neural_activation_unit_defines.svh @@
// Assertion macros shared by the activation unit RTL.
`ifndef NEURAL_ACTIVATION_UNIT_DEFINES_SVH
`define NEURAL_ACTIVATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while arst_n is low
`define NAU_ASSERT_IMP(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error("activation unit check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define NAU_ASSERT_NXT(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error("activation unit check failed");

`else

`define NAU_ASSERT_IMP(lbl, pre, con)
`define NAU_ASSERT_NXT(lbl, pre, con)

`endif

`endif

@@ design/nau_pkg.sv @@
// Shared types, constants and threshold tables of the activation unit.
package nau_pkg;

	localparam int DEF_DATA_WIDTH = 16;
	localparam int FRAC_BITS      = 8;
	localparam int ONE            = 1 << FRAC_BITS;
	localparam int HALF_ONE       = 1 << (FRAC_BITS - 1);
	localparam real INV_ONE       = 1.0 / real'(ONE);
	// one result bit per search step, plus one step for the full count
	localparam int SRCH_BITS      = FRAC_BITS;
	localparam int TAB_DEPTH      = ONE;
	// all thresholds stay below 8.0
	localparam int THR_W          = FRAC_BITS + 3;

	typedef enum logic [2:0] {
		MODE_RELU    = 3'd0,
		MODE_RELU6   = 3'd1,
		MODE_RELU1   = 3'd2,
		MODE_LEAKY6  = 3'd3,
		MODE_SIGMOID = 3'd4,
		MODE_TANH    = 3'd5
	} mode_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
		logic  neg;
	} ctl_t;

	typedef logic [THR_W-1:0] thr_tab_t [TAB_DEPTH];

	// width of the signed intermediate result ahead of saturation
	function automatic int res_width(int dw);
		return (dw > FRAC_BITS + 5) ? dw : FRAC_BITS + 5;
	endfunction

	// Smallest input magnitude whose sigmoid rounds to code HALF_ONE+1+i;
	// entries past the last code repeat the last threshold.
	function automatic thr_tab_t build_sig_tab();
		thr_tab_t tab;
		real      p;
		real      x;
		int       k;
		int       i;
		for (i = 0; i < TAB_DEPTH; i++) begin
			k = (i < HALF_ONE) ? HALF_ONE + 1 + i : ONE;
			p = (real'(k) - 0.5) * INV_ONE;
			x = real'(ONE) * ($ln(p) - $ln(1.0 - p));
			tab[i] = THR_W'(int'($ceil(x)));
		end
		return tab;
	endfunction

	// Smallest input magnitude whose tanh magnitude rounds to code 1+i.
	function automatic thr_tab_t build_tanh_tab();
		thr_tab_t tab;
		real      p;
		real      x;
		int       i;
		for (i = 0; i < TAB_DEPTH; i++) begin
			p = (real'(i) + 0.5) * INV_ONE;
			x = real'(HALF_ONE) * ($ln(1.0 + p) - $ln(1.0 - p));
			tab[i] = THR_W'(int'($ceil(x)));
		end
		return tab;
	endfunction

	localparam thr_tab_t SIG_TAB  = build_sig_tab();
	localparam thr_tab_t TANH_TAB = build_tanh_tab();

endpackage

@@ design/nau_step.sv @@
// One stage of the threshold search: counts table entries at or below the magnitude.
module nau_step #(
	parameter int DATA_WIDTH = nau_pkg::DEF_DATA_WIDTH,
	parameter int STEP       = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nau_pkg::ctl_t               ctl_in,
	input  logic [DATA_WIDTH-1:0]       mag_in,
	input  logic [nau_pkg::SRCH_BITS:0] pos_in,
	output nau_pkg::ctl_t               ctl_s,
	output logic [DATA_WIDTH-1:0]       mag_s,
	output logic [nau_pkg::SRCH_BITS:0] pos_s
);

	localparam int PW = nau_pkg::SRCH_BITS + 1;
	localparam int CW = (DATA_WIDTH > nau_pkg::THR_W) ? DATA_WIDTH : nau_pkg::THR_W;
	localparam logic [PW:0] INC = (PW + 1)'(1 << STEP);
	localparam logic [PW:0] LIM = (PW + 1)'(nau_pkg::TAB_DEPTH);

	logic [PW:0]                      probe;
	logic [PW:0]                      probe_m1;
	logic [nau_pkg::SRCH_BITS-1:0]    idx;
	logic [nau_pkg::THR_W-1:0]        thr;
	logic                             take;
	logic [PW-1:0]                    pos_nxt;

	// probe the entry that would extend the count by 2^STEP
	always_comb begin
		probe    = {1'b0, pos_in} + INC;
		probe_m1 = probe - (PW + 1)'(1);
		idx      = probe_m1[nau_pkg::SRCH_BITS-1:0];
		thr      = (ctl_in.mode == nau_pkg::MODE_TANH) ? nau_pkg::TANH_TAB[idx]
			: nau_pkg::SIG_TAB[idx];
		take     = (probe <= LIM) && (CW'(thr) <= CW'(mag_in));
		pos_nxt  = take ? probe[PW-1:0] : pos_in;
	end

	// advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else begin
			ctl_s <= ctl_in;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		mag_s <= mag_in;
		pos_s <= pos_nxt;
	end

endmodule

@@ design/nau_lin.sv @@
// Piecewise-linear modes: relu, relu6, relu1 and leaky relu6, delayed to the search latency.
module nau_lin #(
	parameter int DATA_WIDTH = nau_pkg::DEF_DATA_WIDTH
) (
	input  logic                                               clk,
	input  nau_pkg::mode_t                                     mode,
	input  logic signed [DATA_WIDTH-1:0]                       q,
	output logic signed [nau_pkg::res_width(DATA_WIDTH)-1:0]   lin_res
);

	localparam int F     = nau_pkg::FRAC_BITS;
	localparam int RW    = nau_pkg::res_width(DATA_WIDTH);
	localparam int CW    = F + 3;
	localparam int SH6   = F + 3;
	localparam int P6W   = CW + SH6;
	localparam logic [SH6-1:0] MUL6 = SH6'((1 << SH6) / 6);
	localparam int SH10  = DATA_WIDTH;
	localparam int P10W  = DATA_WIDTH + SH10;
	localparam logic [63:0] MUL10 = (64'd1 << SH10) / 10;
	localparam logic signed [RW-1:0] SIX = RW'(6 * nau_pkg::ONE);
	localparam int DLY   = nau_pkg::SRCH_BITS - 1;

	logic signed [RW-1:0]         qx;
	logic signed [DATA_WIDTH:0]   qw;
	logic [CW-1:0]                c6;
	logic [CW-1:0]                num6;
	logic [DATA_WIDTH-1:0]        n5;
	logic [P6W-1:0]               prod6;
	logic [P10W-1:0]              prod10;

	nau_pkg::mode_t               mode_s2;
	logic signed [RW-1:0]         qx_s2;
	logic [CW-1:0]                c6_s2;
	logic [CW-1:0]                num6_s2;
	logic [DATA_WIDTH-1:0]        n5_s2;
	logic [P6W-1:0]               prod6_s2;
	logic [P10W-1:0]              prod10_s2;

	logic [CW-1:0]                qt6;
	logic [CW:0]                  rem6;
	logic [CW-1:0]                q6;
	logic [DATA_WIDTH-1:0]        qt10;
	logic [DATA_WIDTH:0]          rem10;
	logic [DATA_WIDTH-1:0]        q10;
	logic signed [RW-1:0]         res_b;

	logic signed [RW-1:0]         lin_s3;
	logic signed [RW-1:0]         lin_dly_s [DLY];

	// clamp to 0..6 and form both dividends with their reciprocal products
	always_comb begin
		qx = RW'(q);
		qw = (DATA_WIDTH + 1)'(q);
		if (qx < 0) begin
			c6 = '0;
		end else if (qx > SIX) begin
			c6 = SIX[CW-1:0];
		end else begin
			c6 = qx[CW-1:0];
		end
		num6   = c6 + CW'(3);
		n5     = DATA_WIDTH'(-qw + 5);
		prod6  = P6W'(num6) * P6W'(MUL6);
		prod10 = P10W'(n5) * P10W'(MUL10);
	end

	always_ff @(posedge clk) begin
		mode_s2   <= mode;
		qx_s2     <= qx;
		c6_s2     <= c6;
		num6_s2   <= num6;
		n5_s2     <= n5;
		prod6_s2  <= prod6;
		prod10_s2 <= prod10;
	end

	// correct each estimated quotient by at most one and pick the mode result
	always_comb begin
		qt6   = prod6_s2[P6W-1:SH6];
		rem6  = (CW + 1)'(num6_s2) - (CW + 1)'(qt6) * (CW + 1)'(6);
		q6    = (rem6 >= (CW + 1)'(6)) ? qt6 + CW'(1) : qt6;
		qt10  = prod10_s2[P10W-1:SH10];
		rem10 = (DATA_WIDTH + 1)'(n5_s2) - (DATA_WIDTH + 1)'(qt10) * (DATA_WIDTH + 1)'(10);
		q10   = (rem10 >= (DATA_WIDTH + 1)'(10)) ? qt10 + DATA_WIDTH'(1) : qt10;
		case (mode_s2)
			nau_pkg::MODE_RELU: begin
				res_b = (qx_s2 < 0) ? '0 : qx_s2;
			end
			nau_pkg::MODE_RELU6: begin
				res_b = RW'(c6_s2);
			end
			nau_pkg::MODE_RELU1: begin
				res_b = RW'(q6);
			end
			nau_pkg::MODE_LEAKY6: begin
				res_b = (qx_s2 <= 0) ? -RW'(q10) : RW'(c6_s2);
			end
			default: begin
				res_b = '0;
			end
		endcase
	end

	// hold the result until the search stages catch up
	always_ff @(posedge clk) begin
		lin_s3       <= res_b;
		lin_dly_s[0] <= lin_s3;
		for (int k = 1; k < DLY; k++) begin
			lin_dly_s[k] <= lin_dly_s[k-1];
		end
	end

	assign lin_res = lin_dly_s[DLY-1];

endmodule

@@ design/neural_activation_unit.sv @@
// Top level of the activation unit: input stage, search chain, result merge.
//
// Channel   Signals                                   Transfer when
// input     start, busy, pre_activation               start high, busy low
// result    done, activated                           done high (one cycle)
// config    cfg_valid, cfg_ready, activation_mode     cfg_valid and cfg_ready high
//
// One item is taken every cycle; busy stays low.
// A result passes the input stage, the threshold search and the result register (data is Q8.8
// by default); the threshold search settles one bit of the output code per stage.
// Reset clears the valid bits and sets the mode to sigmoid; no memory needs clearing.
// Results cannot be held off, so the pipeline never stops.
`include "neural_activation_unit_defines.svh"

module neural_activation_unit #(
	parameter int DATA_WIDTH = nau_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] pre_activation,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] activated,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   activation_mode
);

	localparam int PW   = nau_pkg::SRCH_BITS + 1;
	localparam int LAST = nau_pkg::SRCH_BITS + 1;
	localparam int RW   = nau_pkg::res_width(DATA_WIDTH);
	localparam logic signed [RW-1:0] HALF_R = RW'(nau_pkg::HALF_ONE);
	localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

	nau_pkg::mode_t              mode_q;
	nau_pkg::ctl_t               ctl_s1;
	logic signed [DATA_WIDTH-1:0] q_s1;
	logic [DATA_WIDTH-1:0]       mag_s1;

	nau_pkg::ctl_t               ctl_c [LAST + 1];
	logic [DATA_WIDTH-1:0]       mag_c [LAST + 1];
	logic [PW-1:0]               pos_c [LAST + 1];

	logic signed [RW-1:0]        lin_res;
	logic [PW-1:0]               sig_cnt;
	logic signed [RW-1:0]        fv;
	logic signed [DATA_WIDTH-1:0] sat;

	logic                        done_q;
	logic signed [DATA_WIDTH-1:0] activated_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nau_pkg::MODE_SIGMOID;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= nau_pkg::mode_t'(activation_mode);
		end
	end

	// input stage: take the item, split sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.mode  <= mode_q;
			ctl_s1.neg   <= pre_activation[DATA_WIDTH-1];
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= pre_activation;
		mag_s1 <= pre_activation[DATA_WIDTH-1] ? DATA_WIDTH'(-pre_activation)
			: DATA_WIDTH'(pre_activation);
	end

	assign ctl_c[0] = ctl_s1;
	assign mag_c[0] = mag_s1;
	assign pos_c[0] = '0;

	// threshold search, widest step first
	for (genvar g = 0; g < LAST; g++) begin : g_step
		nau_step #(
			.DATA_WIDTH(DATA_WIDTH),
			.STEP      (nau_pkg::SRCH_BITS - g)
		) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl_in(ctl_c[g]),
			.mag_in(mag_c[g]),
			.pos_in(pos_c[g]),
			.ctl_s (ctl_c[g+1]),
			.mag_s (mag_c[g+1]),
			.pos_s (pos_c[g+1])
		);
	end

	nau_lin #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_lin (
		.clk    (clk),
		.mode   (ctl_s1.mode),
		.q      (q_s1),
		.lin_res(lin_res)
	);

	// merge the code count or linear result, then saturate
	always_comb begin
		sig_cnt = (pos_c[LAST] > PW'(nau_pkg::HALF_ONE)) ? PW'(nau_pkg::HALF_ONE)
			: pos_c[LAST];
		case (ctl_c[LAST].mode)
			nau_pkg::MODE_RELU, nau_pkg::MODE_RELU6, nau_pkg::MODE_RELU1,
			nau_pkg::MODE_LEAKY6: begin
				fv = lin_res;
			end
			nau_pkg::MODE_TANH: begin
				fv = ctl_c[LAST].neg ? -RW'(pos_c[LAST]) : RW'(pos_c[LAST]);
			end
			default: begin
				fv = ctl_c[LAST].neg ? HALF_R - RW'(sig_cnt) : HALF_R + RW'(sig_cnt);
			end
		endcase
		if (fv > RW'(SMAX)) begin
			sat = SMAX;
		end else if (fv < RW'(SMIN)) begin
			sat = SMIN;
		end else begin
			sat = fv[DATA_WIDTH-1:0];
		end
	end

	// result register: one-cycle strobe per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[LAST].valid;
		end
	end

	always_ff @(posedge clk) begin
		activated_q <= sat;
	end

	assign done      = done_q;
	assign activated = activated_q;

	// checks
	`NAU_ASSERT_NXT(a_mode_write, cfg_valid && cfg_ready, 3'(mode_q) == $past(activation_mode))
	`NAU_ASSERT_IMP(a_zero_count, ctl_c[LAST].valid && mag_c[LAST] == '0, pos_c[LAST] == '0)
	`NAU_ASSERT_NXT(a_tanh_range, ctl_c[LAST].valid && ctl_c[LAST].mode == nau_pkg::MODE_TANH, done && activated >= -nau_pkg::ONE && activated <= nau_pkg::ONE)
	`NAU_ASSERT_NXT(a_relu_nonneg, ctl_c[LAST].valid && (ctl_c[LAST].mode == nau_pkg::MODE_RELU || ctl_c[LAST].mode == nau_pkg::MODE_RELU6 || ctl_c[LAST].mode == nau_pkg::MODE_RELU1), done && activated >= 0)

endmodule
